[sv/analog_control_to_midi_encoder_macros.svh]
// Assertion helpers used by the encoder top level.
`ifndef ANALOG_CONTROL_TO_MIDI_ENCODER_MACROS_SVH
`define ANALOG_CONTROL_TO_MIDI_ENCODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ACTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ACTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/actm_pkg.sv]
package actm_pkg;

    localparam int NUM_CONTROLS = 64;
    localparam int AW = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
    localparam int VAL_W = 15;

    localparam logic [2:0] KIND_CC     = 3'd0;
    localparam logic [2:0] KIND_NOTE   = 3'd1;
    localparam logic [2:0] KIND_NRPN7  = 3'd2;
    localparam logic [2:0] KIND_NRPN14 = 3'd3;
    localparam logic [2:0] KIND_BEND   = 3'd4;
    localparam logic [2:0] KIND_CC14   = 3'd5;

    localparam logic [1:0] MSG_CC   = 2'd0;
    localparam logic [1:0] MSG_NOTE = 2'd1;
    localparam logic [1:0] MSG_BEND = 2'd2;

    localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
    localparam logic [6:0] CC_DATA_MSB   = 7'd6;
    localparam logic [6:0] CC_DATA_LSB   = 7'd38;
    localparam logic [6:0] CC14_OFFSET   = 7'd32;
    localparam logic [6:0] CC14_LIMIT    = 7'd96;

    typedef struct packed {
        logic        invert_output;
        logic [3:0]  midi_channel;
        logic [13:0] upper_limit;
        logic [13:0] lower_limit;
        logic [13:0] midi_number;
        logic [2:0]  ctrl_type;
        logic [15:0] raw_value;
        logic [5:0]  analog_id;
    } t_in;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } t_scale_ctl;

    typedef struct packed {
        logic [13:0] value;
        logic [13:0] num;
        logic        drop;
    } t_scale_out;

endpackage

[sv/analog_control_to_midi_encoder.sv]
// Channel   | Direction | Ports               | Payload
// control   | in        | i_s_axis_*          | reading and settings of one control
// message   | out       | o_m_axis_*          | one MIDI message, tlast on the final one
//
// An accepted request passes through the multiply, divide and compare-and-write-back states,
// then loads one message per cycle while the output register is free; a new request is
// taken only once the block is back in the idle state.
// Reset is synchronous, active low, and marks every stored value as never sent.
// A stalled message stays in the output register; the next request can be taken
// while the final message of the previous one still waits.
`include "analog_control_to_midi_encoder_macros.svh"

module analog_control_to_midi_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // analog_id[5:0], raw_value[21:6], midi_number[35:22], lower_limit[49:36],
    // upper_limit[63:50], midi_channel[67:64], invert_output[68], zeros[71:69]
    input  logic [71:0] i_s_axis_tdata,
    // ctrl_type[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // msg_number[6:0], msg_value[20:7], msg_channel[24:21], zeros[31:25]
    output logic [31:0] o_m_axis_tdata,
    // msg_kind[1:0]
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    import actm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  number;
        logic [13:0] value;
    } t_msg;

    function automatic logic [2:0] msg_count(input logic [2:0] kind, input logic [13:0] num);
        logic [2:0] n;
        case (kind)
            KIND_CC:     n = 3'd1;
            KIND_NOTE:   n = 3'd1;
            KIND_NRPN7:  n = 3'd3;
            KIND_NRPN14: n = 3'd4;
            KIND_BEND:   n = 3'd1;
            KIND_CC14:   n = (num[6:0] < CC14_LIMIT) ? 3'd2 : 3'd0;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic t_msg build_msg(input logic [2:0] kind, input logic [1:0] idx,
                                       input logic [13:0] num, input logic [13:0] value);
        t_msg m;
        m = '0;
        case (kind)
            KIND_CC: begin
                m = '{MSG_CC, num[6:0], value};
            end
            KIND_NOTE: begin
                m = '{MSG_NOTE, num[6:0], value};
            end
            KIND_NRPN7: begin
                case (idx)
                    2'd0:    m = '{MSG_CC, CC_NRPN_MSB, {7'd0, num[13:7]}};
                    2'd1:    m = '{MSG_CC, CC_NRPN_LSB, {7'd0, num[6:0]}};
                    default: m = '{MSG_CC, CC_DATA_MSB, value};
                endcase
            end
            KIND_NRPN14: begin
                case (idx)
                    2'd0:    m = '{MSG_CC, CC_NRPN_MSB, {7'd0, num[13:7]}};
                    2'd1:    m = '{MSG_CC, CC_NRPN_LSB, {7'd0, num[6:0]}};
                    2'd2:    m = '{MSG_CC, CC_DATA_MSB, {7'd0, value[13:7]}};
                    default: m = '{MSG_CC, CC_DATA_LSB, {7'd0, value[6:0]}};
                endcase
            end
            KIND_BEND: begin
                m = '{MSG_BEND, 7'd0, value};
            end
            KIND_CC14: begin
                case (idx)
                    2'd0:    m = '{MSG_CC, num[6:0], {7'd0, value[13:7]}};
                    default: m = '{MSG_CC, num[6:0] + CC14_OFFSET, {7'd0, value[6:0]}};
                endcase
            end
            default: begin
                m = '0;
            end
        endcase
        return m;
    endfunction

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    t_in                     r_in;
    logic [NUM_CONTROLS-1:0] r_vld;
    logic                    r_hit;
    logic [2:0]              r_cnt;
    logic [1:0]              r_idx;
    logic                    r_out_valid;
    t_msg                    r_out_msg;
    logic [3:0]              r_out_ch;
    logic                    r_out_last;

    logic                    in_acc;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [VAL_W-1:0]        rd_data;
    logic [VAL_W-1:0]        last_val;
    logic [VAL_W-1:0]        new_val;
    logic                    changed;
    logic                    ram_we;
    logic [2:0]              cnt;
    logic                    out_free;
    logic                    msg_last;
    t_msg                    msg;
    t_scale_ctl              scale_ctl;
    t_scale_out              scale_res;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign rd_addr         = i_s_axis_tdata[AW-1:0];
    assign wr_addr         = r_in.analog_id[AW-1:0];

    assign scale_ctl.ld_a = (r_state == S_MUL);
    assign scale_ctl.ld_b = (r_state == S_DIV);

    actm_scale u_scale (
        .i_clk  (i_clk),
        .i_item (r_in),
        .i_ctl  (scale_ctl),
        .o_res  (scale_res)
    );

    actm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_CONTROLS)
    ) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (new_val),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // An entry never written since reset reads as all ones.
    always_comb begin
        last_val = r_hit ? rd_data : '1;
        new_val  = {1'b0, scale_res.value};
        changed  = new_val != last_val;
        ram_we   = (r_state == S_CMP) && !scale_res.drop && changed;
        cnt      = msg_count(r_in.ctrl_type, scale_res.num);
        out_free = !r_out_valid || i_m_axis_tready;
        msg_last = ({1'b0, r_idx} + 3'd1) == r_cnt;
        msg      = build_msg(r_in.ctrl_type, r_idx, scale_res.num, scale_res.value);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_CMP;
            S_CMP:  n_state = (ram_we && (cnt != 3'd0)) ? S_OUT : S_IDLE;
            S_OUT:  if (out_free && msg_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= 3'd0;
            r_idx       <= 2'd0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (r_state == S_CMP) begin
                r_cnt <= cnt;
                r_idx <= 2'd0;
            end else if ((r_state == S_OUT) && out_free) begin
                r_idx <= r_idx + 2'd1;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The channel is held with the message, since the next request may overwrite r_in.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in  <= {i_s_axis_tdata[68:22], i_s_axis_tuser, i_s_axis_tdata[21:0]};
            r_hit <= r_vld[rd_addr];
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_msg  <= msg;
            r_out_ch   <= r_in.midi_channel;
            r_out_last <= msg_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_ch, r_out_msg.value, r_out_msg.number};
    assign o_m_axis_tuser  = r_out_msg.kind;
    assign o_m_axis_tlast  = r_out_last;

    `ACTM_ASSERT_IMP(a_out_count, i_clk, i_rst_n, r_state == S_OUT, ({1'b0, r_idx} < r_cnt))
    `ACTM_ASSERT_IMP(a_write_in_cmp, i_clk, i_rst_n, ram_we, (r_state == S_CMP) && changed)
    `ACTM_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n, (r_state == S_OUT) && out_free && msg_last,
                     (r_state == S_IDLE) && o_m_axis_tlast)
    `ACTM_ASSERT_NXT(a_written_valid, i_clk, i_rst_n, ram_we, r_vld[$past(wr_addr)])

endmodule

[sv/actm_ram.sv]
module actm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/actm_scale.sv]
module actm_scale (
    input  logic                   i_clk,
    input  actm_pkg::t_in          i_item,
    input  actm_pkg::t_scale_ctl   i_ctl,
    output actm_pkg::t_scale_out   o_res
);

    import actm_pkg::*;

    // Quotient by 2^k - 1 for operands up to (2^k - 1)^2.
    function automatic logic [13:0] div_span(input logic [27:0] x, input logic wide);
        logic [28:0] s14;
        logic [14:0] s7;
        s14 = {1'b0, x} + {15'd0, x[27:14]} + 29'd1;
        s7  = {1'b0, x[13:0]} + {8'd0, x[13:7]} + 15'd1;
        return wide ? s14[27:14] : {7'd0, s7[13:7]};
    endfunction

    logic        wide;
    logic [13:0] num_m;
    logic [13:0] lower_m;
    logic [13:0] upper_m;
    logic        over;
    logic        swap;
    logic [13:0] lo;
    logic [13:0] diff;
    logic        unknown;
    logic        bad_id;

    logic [27:0] r_prod;
    logic [13:0] r_lo;
    logic [14:0] r_sum;
    logic        r_refl;
    logic        r_wide;
    logic        r_drop_a;
    logic [13:0] r_num_a;

    logic [13:0] q;
    logic [14:0] v_add;
    logic [14:0] v_ref;
    logic [13:0] n_value;
    t_scale_out  r_res;

    always_comb begin
        wide    = (i_item.ctrl_type == KIND_NRPN14) || (i_item.ctrl_type == KIND_BEND)
                  || (i_item.ctrl_type == KIND_CC14);
        num_m   = wide ? i_item.midi_number : {7'd0, i_item.midi_number[6:0]};
        lower_m = wide ? i_item.lower_limit : {7'd0, i_item.lower_limit[6:0]};
        upper_m = wide ? i_item.upper_limit : {7'd0, i_item.upper_limit[6:0]};
        over    = wide ? (|i_item.raw_value[15:14]) : (|i_item.raw_value[15:7]);
        swap    = lower_m > upper_m;
        lo      = swap ? upper_m : lower_m;
        diff    = swap ? (lower_m - upper_m) : (upper_m - lower_m);
        unknown = i_item.ctrl_type > KIND_CC14;
        bad_id  = int'(i_item.analog_id) >= NUM_CONTROLS;
    end

    // First stage: the one multiplication.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_prod   <= i_item.raw_value[13:0] * diff;
            r_lo     <= lo;
            r_sum    <= {1'b0, lower_m} + {1'b0, upper_m};
            r_refl   <= i_item.invert_output ^ swap;
            r_wide   <= wide;
            r_drop_a <= over || unknown || bad_id;
            r_num_a  <= num_m;
        end
    end

    // Second stage: divide by the full-scale reading, offset and reflect.
    always_comb begin
        q       = div_span(r_prod, r_wide);
        v_add   = {1'b0, r_lo} + {1'b0, q};
        v_ref   = r_sum - v_add;
        n_value = r_refl ? v_ref[13:0] : v_add[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_b) begin
            r_res.value <= n_value;
            r_res.num   <= r_num_a;
            r_res.drop  <= r_drop_a;
        end
    end

    assign o_res = r_res;

endmodule

[sim/analog_control_to_midi_encoder_test.sv]
`timescale 1ns / 1ps

module analog_control_to_midi_encoder_test;
    import actm_pkg::*;

    // Kinds 6 and 7 carry no meaning and must be dropped.
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int unsigned SPAN_7 = 127;
    localparam int unsigned SPAN_14 = 16383;
    localparam logic [14:0] NEVER_SENT = 15'h7FFF;
    localparam int REPORT_LINES = 50;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  number;
        logic [13:0] value;
        logic [3:0]  channel;
        logic        last;
    } t_midi_msg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;

    logic [14:0] last_sent_value [NUM_CONTROLS];
    t_midi_msg   pending_messages [$];
    t_in         previous_reading;

    analog_control_to_midi_encoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        // Keep the log short when the block is badly broken.
        if (error_count <= REPORT_LINES) begin
            $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic t_midi_msg make_msg(input logic [1:0] kind, input logic [6:0] number,
                                           input logic [13:0] value, input logic [3:0] channel);
        make_msg = {kind, number, value, channel, 1'b0};
    endfunction

    // Works out the messages one accepted request causes and updates the stored values.
    function automatic void predict_messages(input t_in r);
        logic [13:0] number;
        logic [13:0] lower;
        logic [13:0] upper;
        logic [13:0] lo;
        logic [13:0] hi;
        logic [3:0]  ch;
        logic        wide;
        int unsigned top;
        int unsigned level;
        t_midi_msg   batch [4];
        int          count;
        int          i;
        count = 0;
        ch = r.midi_channel;
        wide = (r.ctrl_type == KIND_NRPN14) || (r.ctrl_type == KIND_BEND) ||
               (r.ctrl_type == KIND_CC14);
        number = r.midi_number;
        lower = r.lower_limit;
        upper = r.upper_limit;
        if (!wide) begin
            number = {7'b0, number[6:0]};
            lower = {7'b0, lower[6:0]};
            upper = {7'b0, upper[6:0]};
        end
        top = wide ? SPAN_14 : SPAN_7;
        if (r.raw_value > top || r.ctrl_type > KIND_CC14) begin
            return;
        end
        lo = (lower < upper) ? lower : upper;
        hi = (lower < upper) ? upper : lower;
        level = lo + (r.raw_value * (hi - lo)) / top;
        if (r.invert_output != (lower > upper)) begin
            level = lower + upper - level;
        end
        if (level[14:0] == last_sent_value[r.analog_id]) begin
            return;
        end
        case (r.ctrl_type)
            KIND_CC: begin
                batch[0] = make_msg(MSG_CC, number[6:0], level[13:0], ch);
                count = 1;
            end
            KIND_NOTE: begin
                batch[0] = make_msg(MSG_NOTE, number[6:0], level[13:0], ch);
                count = 1;
            end
            KIND_NRPN7: begin
                batch[0] = make_msg(MSG_CC, CC_NRPN_MSB, {7'b0, number[13:7]}, ch);
                batch[1] = make_msg(MSG_CC, CC_NRPN_LSB, {7'b0, number[6:0]}, ch);
                batch[2] = make_msg(MSG_CC, CC_DATA_MSB, level[13:0], ch);
                count = 3;
            end
            KIND_NRPN14: begin
                batch[0] = make_msg(MSG_CC, CC_NRPN_MSB, {7'b0, number[13:7]}, ch);
                batch[1] = make_msg(MSG_CC, CC_NRPN_LSB, {7'b0, number[6:0]}, ch);
                batch[2] = make_msg(MSG_CC, CC_DATA_MSB, {7'b0, level[13:7]}, ch);
                batch[3] = make_msg(MSG_CC, CC_DATA_LSB, {7'b0, level[6:0]}, ch);
                count = 4;
            end
            KIND_BEND: begin
                batch[0] = make_msg(MSG_BEND, 7'd0, level[13:0], ch);
                count = 1;
            end
            default: begin
                // High controller numbers have no partner at +32; the value is still stored.
                if (number[6:0] < CC14_LIMIT) begin
                    batch[0] = make_msg(MSG_CC, number[6:0], {7'b0, level[13:7]}, ch);
                    batch[1] = make_msg(MSG_CC, number[6:0] + CC14_OFFSET,
                                        {7'b0, level[6:0]}, ch);
                    count = 2;
                end
            end
        endcase
        for (i = 0; i < count; i++) begin
            batch[i].last = (i == count - 1);
            pending_messages.push_back(batch[i]);
        end
        last_sent_value[r.analog_id] = level[14:0];
    endfunction

    function automatic t_in reading(input int id, input int raw, input logic [2:0] kind,
                                    input int number, input int lower, input int upper,
                                    input int channel, input logic invert);
        t_in r;
        r.analog_id = 6'(id);
        r.raw_value = 16'(raw);
        r.ctrl_type = kind;
        r.midi_number = 14'(number);
        r.lower_limit = 14'(lower);
        r.upper_limit = 14'(upper);
        r.midi_channel = 4'(channel);
        r.invert_output = invert;
        reading = r;
    endfunction

    function automatic t_in random_reading();
        t_in         r;
        int unsigned top;
        int          sel;
        logic        wide;
        if ($urandom_range(0, 99) < 8) begin
            // Repeating a request exercises the unchanged-value path.
            r = previous_reading;
        end else begin
            r.analog_id = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom);
            r.ctrl_type = ($urandom_range(0, 99) < 6) ?
                          3'($urandom_range(KIND_SPARE_A, KIND_SPARE_B)) :
                          3'($urandom_range(KIND_CC, KIND_CC14));
            wide = (r.ctrl_type == KIND_NRPN14) || (r.ctrl_type == KIND_BEND) ||
                   (r.ctrl_type == KIND_CC14);
            top = wide ? SPAN_14 : SPAN_7;
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                r.raw_value = 16'($urandom);
            end else if (sel < 22) begin
                r.raw_value = $urandom_range(0, 1) ? 16'(top) : 16'd0;
            end else begin
                r.raw_value = 16'($urandom_range(0, top));
            end
            r.midi_number = 14'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                r.lower_limit = $urandom_range(0, 1) ? 14'(top) : 14'd0;
                r.upper_limit = (r.lower_limit == 14'd0) ? 14'(top) : 14'd0;
            end else if (sel < 30) begin
                r.lower_limit = 14'($urandom);
                r.upper_limit = r.lower_limit;
            end else begin
                r.lower_limit = 14'($urandom);
                r.upper_limit = 14'($urandom);
            end
            r.midi_channel = 4'($urandom);
            r.invert_output = 1'($urandom);
        end
        previous_reading = r;
        random_reading = r;
    endfunction

    task automatic send_reading(input t_in r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tuser = r.ctrl_type;
        s_tdata = {3'b0, r.invert_output, r.midi_channel, r.upper_limit, r.lower_limit,
                   r.midi_number, r.raw_value, r.analog_id};
        do @(posedge i_clk); while (!s_tready);
        predict_messages(r);
    endtask

    always @(posedge i_clk) begin : check_messages
        t_midi_msg want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_messages.size() == 0) begin
                report_mismatch("message with nothing pending, tdata", m_tdata, 0);
            end else begin
                want = pending_messages.pop_front();
                if (m_tuser != want.kind) begin
                    report_mismatch("msg_kind", m_tuser, want.kind);
                end
                if (m_tdata[6:0] != want.number) begin
                    report_mismatch("msg_number", m_tdata[6:0], want.number);
                end
                if (m_tdata[20:7] != want.value) begin
                    report_mismatch("msg_value", m_tdata[20:7], want.value);
                end
                if (m_tdata[24:21] != want.channel) begin
                    report_mismatch("msg_channel", m_tdata[24:21], want.channel);
                end
                if (m_tlast != want.last) begin
                    report_mismatch("last_of_run", m_tlast, want.last);
                end
            end
        end
    end

    task automatic test_field_extremes();
        send_reading(reading(0, 0, KIND_CC, 0, 0, 127, 0, 1'b0));
        send_reading(reading(0, 127, KIND_CC, 127, 0, 127, 15, 1'b0));
        send_reading(reading(63, 127, KIND_NRPN14, 16383, 0, 16383, 15, 1'b1));
        send_reading(reading(62, 16383, KIND_BEND, 0, 0, 16383, 9, 1'b0));
        // Reversed limits reflect on their own, and invert cancels that.
        send_reading(reading(61, 0, KIND_BEND, 0, 16383, 0, 3, 1'b0));
        send_reading(reading(60, 0, KIND_BEND, 0, 16383, 0, 3, 1'b1));
        send_reading(reading(59, 127, KIND_CC, 16383, 16383, 16383, 15, 1'b1));
    endtask

    task automatic test_every_kind();
        int k;
        for (k = KIND_CC; k <= KIND_SPARE_B; k++) begin
            send_reading(reading(8 + k, 100, 3'(k), 16'h2A55, 5, 9000, k, k[0]));
        end
    endtask

    task automatic test_special_cases();
        send_reading(reading(0, 128, KIND_CC, 1, 0, 127, 1, 1'b0));
        send_reading(reading(3, 16384, KIND_NRPN14, 1, 0, 16383, 1, 1'b0));
        send_reading(reading(4, 65535, KIND_CC14, 1, 0, 16383, 1, 1'b0));
        // Same value as an earlier request on this control: nothing goes out.
        send_reading(reading(0, 127, KIND_CC, 127, 0, 127, 15, 1'b0));
        send_reading(reading(20, 5, KIND_CC14, 96, 0, 16383, 2, 1'b0));
        send_reading(reading(20, 5, KIND_CC14, 10, 0, 16383, 2, 1'b0));
        send_reading(reading(20, 6, KIND_CC14, 10, 0, 16383, 2, 1'b0));
        send_reading(reading(21, 16383, KIND_CC14, 95, 0, 16383, 4, 1'b0));
        // A spare kind must not store its value.
        send_reading(reading(22, 50, KIND_SPARE_A, 7, 0, 127, 5, 1'b0));
        send_reading(reading(22, 50, KIND_CC, 7, 0, 127, 5, 1'b0));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int goal);
        int counted;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (counted = 0; counted < goal; counted++) begin
            send_reading(random_reading());
        end
    endtask

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_CONTROLS; i++) begin
            last_sent_value[i] = NEVER_SENT;
        end
        previous_reading = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_extremes();
        test_every_kind();
        test_special_cases();
        test_random_traffic(0, 0, 101);
        test_random_traffic(55, 0, 101);
        test_random_traffic(0, 55, 101);
        test_random_traffic(34, 34, 101);

        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_messages.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
